// File: rtl/ibma_pkg.sv
// ----------------------------------------------------------------------------
// ibma_pkg
// Shared types and codes for the inode and block map allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ibma_pkg;

    localparam int BM_WORD_W = 32;
    localparam int BM_POS_W  = 5;
    localparam int BM_IDX_W  = 16;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_EXTEND = 3'd1,
        OP_GET    = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INODE_FREE = 3'd1,
        ST_NO_INODE   = 3'd2,
        ST_NO_BLOCK   = 3'd3,
        ST_FULL       = 3'd4,
        ST_RANGE      = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] inode_number;
        logic       is_directory;
        logic [8:0] block_index;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] new_inode;
        logic [9:0] blk_num;
    } t_rsp;

    // bitmap unit commands
    typedef enum logic [1:0] {
        BM_NONE  = 2'd0,
        BM_ALLOC = 2'd1,
        BM_FREE  = 2'd2,
        BM_TEST  = 2'd3
    } t_bm_op;

    typedef struct packed {
        t_bm_op                op;
        logic [BM_IDX_W-1:0]   idx;
    } t_bm_req;

    typedef struct packed {
        logic                  ready;
        logic                  done;
        logic                  found;
        logic [BM_IDX_W-1:0]   idx;
    } t_bm_rsp;

    typedef enum logic [1:0] {
        BMS_CLR,
        BMS_IDLE,
        BMS_RD,
        BMS_CHK
    } t_bm_state;

    // where a block being released comes from
    typedef enum logic [1:0] {
        SRC_DIR,
        SRC_IND,
        SRC_EXT
    } t_src;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CR_WAIT,
        S_LIVE_WAIT,
        S_CNT_RD,
        S_CNT,
        S_GROW,
        S_GR_WAIT,
        S_EXT_REQ,
        S_EXT_WAIT,
        S_MAP_RD,
        S_MAP,
        S_RL_NEXT,
        S_RL_DATA,
        S_RL_WAIT,
        S_RL_END,
        S_FRB_REQ,
        S_FRB_WAIT,
        S_FRI_REQ,
        S_FRI_WAIT,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// File: rtl/ibma_bmap.sv
// ----------------------------------------------------------------------------
// ibma_bmap
// Taken-bit map in a word-wide memory: clear pass, first-free allocate,
// free and test; allocate and free update one word by read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module ibma_bmap #(
    parameter int N = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ibma_pkg::t_bm_req i_req,
    output ibma_pkg::t_bm_rsp      o_rsp
);
    import ibma_pkg::*;

    localparam int NW = (N + BM_WORD_W - 1) / BM_WORD_W;
    localparam int WI = (NW > 1) ? $clog2(NW) : 1;

    logic [BM_WORD_W-1:0] mem [NW];
    logic [BM_WORD_W-1:0] r_rd;

    t_bm_state         r_state, n_state;
    t_bm_op            r_op, n_op;
    logic [WI-1:0]     r_w, n_w;
    logic [BM_POS_W-1:0] r_p, n_p;
    logic              r_hit, n_hit;

    logic                 we;
    logic [BM_WORD_W-1:0] wd;
    logic [BM_WORD_W-1:0] vmask, free_bits;
    logic [BM_POS_W-1:0]  pos;
    logic                 any_free, last_w;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_w] <= wd;
        end
        r_rd <= mem[r_w];
    end

    always_comb begin
        for (int p = 0; p < BM_WORD_W; p++) begin
            vmask[p] = ((32'(r_w) * BM_WORD_W) + p) < N;
        end
        free_bits = ~r_rd & vmask;
        pos = '0;
        for (int p = BM_WORD_W - 1; p >= 0; p--) begin
            if (free_bits[p]) begin
                pos = BM_POS_W'(p);
            end
        end
        any_free = |free_bits;
        last_w   = r_w == WI'(NW - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BMS_CLR: begin
                if (last_w) begin
                    n_state = BMS_IDLE;
                end
            end
            BMS_IDLE: begin
                if (i_req.op != BM_NONE) begin
                    n_state = BMS_RD;
                end
            end
            BMS_RD: n_state = BMS_CHK;
            BMS_CHK: begin
                if (r_op == BM_ALLOC && !any_free && !last_w) begin
                    n_state = BMS_RD;
                end else begin
                    n_state = BMS_IDLE;
                end
            end
            default: n_state = BMS_IDLE;
        endcase
    end

    always_comb begin
        n_op  = r_op;
        n_w   = r_w;
        n_p   = r_p;
        n_hit = r_hit;
        we    = 1'b0;
        wd    = '0;
        o_rsp = '0;
        case (r_state)
            BMS_CLR: begin
                we  = 1'b1;
                n_w = r_w + 1'b1;
            end
            BMS_IDLE: begin
                o_rsp.ready = 1'b1;
                n_op  = i_req.op;
                n_p   = i_req.idx[BM_POS_W-1:0];
                n_hit = 32'(i_req.idx) < N;
                n_w   = (i_req.op == BM_ALLOC) ? '0 : WI'(i_req.idx >> BM_POS_W);
            end
            BMS_CHK: begin
                case (r_op)
                    BM_ALLOC: begin
                        if (any_free) begin
                            we = 1'b1;
                            wd = r_rd | (BM_WORD_W'(1) << pos);
                            o_rsp.done  = 1'b1;
                            o_rsp.found = 1'b1;
                            o_rsp.idx   = BM_IDX_W'({r_w, pos});
                        end else if (last_w) begin
                            o_rsp.done = 1'b1;
                        end else begin
                            n_w = r_w + 1'b1;
                        end
                    end
                    BM_FREE: begin
                        we = r_hit;
                        wd = r_rd & ~(BM_WORD_W'(1) << r_p);
                        o_rsp.done  = 1'b1;
                        o_rsp.found = 1'b1;
                    end
                    BM_TEST: begin
                        o_rsp.done  = 1'b1;
                        o_rsp.found = r_hit & r_rd[r_p];
                    end
                    default: o_rsp.done = 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BMS_CLR;
            r_w     <= '0;
            r_op    <= BM_NONE;
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_op    <= n_op;
        end
        r_p   <= n_p;
        r_hit <= n_hit;
    end

endmodule

`default_nettype wire

// File: rtl/inode_block_map_allocator.sv
// ----------------------------------------------------------------------------
// inode_block_map_allocator
// Inode and data block allocator with a per-inode direct/indirect block map.
// ----------------------------------------------------------------------------
// latency varies by request: bitmap scans read and check one 32-entry word
// at a time, get block runs the inode test, count read and map read before
// its result, and clear and delete free each mapped block in turn. one
// request at a time; busy stays high through the result beat, a one-cycle
// o_valid strobe the receiver cannot stall. after reset both bitmaps run a
// clearing pass over every word with busy high.
`default_nettype none

module inode_block_map_allocator #(
    parameter int NUM_INODES  = 64,
    parameter int NUM_BLOCKS  = 1024,
    parameter int DIRECT_REFS = 10,
    parameter int INDIR_REFS  = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire ibma_pkg::t_req i_req,
    output logic                busy,
    output logic                o_valid,
    output ibma_pkg::t_rsp      o_rsp
);
    import ibma_pkg::*;

    localparam int INO_W     = $clog2(NUM_INODES);
    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(DIRECT_REFS + INDIR_REFS + 1);
    localparam int IX_W      = (CNT_W > 9) ? CNT_W : 9;
    localparam int DIR_DEPTH = NUM_INODES * DIRECT_REFS;
    localparam int IND_DEPTH = NUM_INODES * INDIR_REFS;
    localparam int DA_W      = $clog2(DIR_DEPTH);
    localparam int IA_W      = $clog2(IND_DEPTH);

    // map stores
    logic [CNT_W-1:0] mem_cnt [NUM_INODES];
    logic [BLK_W-1:0] mem_dir [DIR_DEPTH];
    logic [BLK_W-1:0] mem_ext [NUM_INODES];
    logic [BLK_W-1:0] mem_ind [IND_DEPTH];
    logic [CNT_W-1:0] r_cnt_rd;
    logic [BLK_W-1:0] r_dir_rd, r_ext_rd, r_ind_rd;

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [INO_W-1:0]   r_ino, n_ino;
    logic               r_isdir, n_isdir;
    logic [8:0]         r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_i, n_i;
    logic               r_ext_done, n_ext_done;
    t_src               r_src, n_src;
    logic [BLK_W-1:0]   r_nb, n_nb;
    logic [BLK_W-1:0]   r_blk, n_blk;
    logic [2:0]         r_status, n_status;
    logic [INO_W-1:0]   r_newi, n_newi;

    t_bm_req ib_req, bb_req;
    t_bm_rsp ib_rsp, bb_rsp;

    logic               cnt_we, dir_we, ext_we, ind_we;
    logic [INO_W-1:0]   cnt_wa;
    logic [CNT_W-1:0]   cnt_wd;
    logic [DA_W-1:0]    dir_base, dir_wa, dir_ra;
    logic [IA_W-1:0]    ind_base, ind_wa, ind_ra;
    logic [BLK_W-1:0]   map_wd;
    logic [IX_W-1:0]    sub;

    logic accept, in_range, is_direct, has_room, first_ind, get_range, idx_direct;
    logic rl_more, rl_ext;
    logic [INO_W-1:0] ib_ino;
    logic [BLK_W-1:0] bb_blk, free_blk;

    ibma_bmap #(.N(NUM_INODES)) u_inode_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ib_req),
        .o_rsp   (ib_rsp)
    );

    ibma_bmap #(.N(NUM_BLOCKS)) u_block_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bb_req),
        .o_rsp   (bb_rsp)
    );

    assign busy   = (r_state != S_IDLE) || !ib_rsp.ready || !bb_rsp.ready;
    assign accept = start && !busy;

    always_comb begin
        in_range   = 32'(i_req.inode_number) < 32'(NUM_INODES);
        ib_ino     = INO_W'(ib_rsp.idx);
        bb_blk     = BLK_W'(bb_rsp.idx);
        is_direct  = r_cnt < CNT_W'(DIRECT_REFS);
        has_room   = r_cnt < CNT_W'(DIRECT_REFS + INDIR_REFS);
        first_ind  = r_cnt == CNT_W'(DIRECT_REFS);
        get_range  = IX_W'(r_idx) >= IX_W'(r_cnt_rd);
        idx_direct = 32'(r_idx) < 32'(DIRECT_REFS);
        rl_more    = r_i < r_cnt;
        rl_ext     = (r_cnt > CNT_W'(DIRECT_REFS)) && !r_ext_done;
        sub        = (r_state == S_MAP_RD) ? IX_W'(r_idx) : IX_W'(r_i);
        dir_base   = DA_W'(32'(r_ino) * DIRECT_REFS);
        ind_base   = IA_W'(32'(r_ino) * INDIR_REFS);
        dir_ra     = dir_base + DA_W'(sub);
        ind_ra     = ind_base + IA_W'(32'(sub) - DIRECT_REFS);
        dir_wa     = dir_base + DA_W'(r_cnt);
        ind_wa     = ind_base + IA_W'(32'(r_cnt) - DIRECT_REFS);
        case (r_src)
            SRC_DIR: free_blk = r_dir_rd;
            SRC_IND: free_blk = r_ind_rd;
            default: free_blk = r_ext_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        if (dir_we) begin
            mem_dir[dir_wa] <= map_wd;
        end
        if (ext_we) begin
            mem_ext[r_ino] <= bb_blk;
        end
        if (ind_we) begin
            mem_ind[ind_wa] <= map_wd;
        end
        r_cnt_rd <= mem_cnt[r_ino];
        r_dir_rd <= mem_dir[dir_ra];
        r_ext_rd <= mem_ext[r_ino];
        r_ind_rd <= mem_ind[ind_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        OP_CREATE: n_state = S_CR_WAIT;
                        OP_EXTEND, OP_GET, OP_CLEAR, OP_DELETE:
                            n_state = in_range ? S_LIVE_WAIT : S_RESP;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_CR_WAIT: begin
                if (ib_rsp.done) begin
                    n_state = (ib_rsp.found && r_isdir) ? S_GROW : S_RESP;
                end
            end
            S_LIVE_WAIT: begin
                if (ib_rsp.done) begin
                    n_state = ib_rsp.found ? S_CNT_RD : S_RESP;
                end
            end
            S_CNT_RD: n_state = S_CNT;
            S_CNT: begin
                case (r_op)
                    OP_EXTEND: n_state = S_GROW;
                    OP_GET:    n_state = get_range ? S_RESP : S_MAP_RD;
                    OP_CLEAR, OP_DELETE: n_state = S_RL_NEXT;
                    default:   n_state = S_RESP;
                endcase
            end
            S_GROW: begin
                if (bb_rsp.ready) begin
                    n_state = S_GR_WAIT;
                end
            end
            S_GR_WAIT: begin
                if (bb_rsp.done) begin
                    if (!bb_rsp.found) begin
                        n_state = (r_op == OP_CREATE) ? S_FRI_REQ : S_RESP;
                    end else if (is_direct) begin
                        n_state = S_RESP;
                    end else if (has_room) begin
                        n_state = first_ind ? S_EXT_REQ : S_RESP;
                    end else begin
                        n_state = S_FRB_REQ;
                    end
                end
            end
            S_EXT_REQ: begin
                if (bb_rsp.ready) begin
                    n_state = S_EXT_WAIT;
                end
            end
            S_EXT_WAIT: begin
                if (bb_rsp.done) begin
                    n_state = bb_rsp.found ? S_RESP : S_FRB_REQ;
                end
            end
            S_MAP_RD: n_state = S_MAP;
            S_MAP:    n_state = S_RESP;
            S_RL_NEXT: begin
                n_state = (rl_more || rl_ext) ? S_RL_DATA : S_RL_END;
            end
            S_RL_DATA: begin
                if (bb_rsp.ready) begin
                    n_state = S_RL_WAIT;
                end
            end
            S_RL_WAIT: begin
                if (bb_rsp.done) begin
                    n_state = S_RL_NEXT;
                end
            end
            S_RL_END: n_state = (r_op == OP_DELETE) ? S_FRI_REQ : S_RESP;
            S_FRB_REQ: begin
                if (bb_rsp.ready) begin
                    n_state = S_FRB_WAIT;
                end
            end
            S_FRB_WAIT: begin
                if (bb_rsp.done) begin
                    n_state = S_RESP;
                end
            end
            S_FRI_REQ: begin
                if (ib_rsp.ready) begin
                    n_state = S_FRI_WAIT;
                end
            end
            S_FRI_WAIT: begin
                if (ib_rsp.done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory writes and bitmap requests
    always_comb begin
        n_op       = r_op;
        n_ino      = r_ino;
        n_isdir    = r_isdir;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_ext_done = r_ext_done;
        n_src      = r_src;
        n_nb       = r_nb;
        n_blk      = r_blk;
        n_status   = r_status;
        n_newi     = r_newi;
        cnt_we     = 1'b0;
        cnt_wa     = r_ino;
        cnt_wd     = r_cnt + 1'b1;
        dir_we     = 1'b0;
        ext_we     = 1'b0;
        ind_we     = 1'b0;
        map_wd     = bb_blk;
        ib_req     = '0;
        bb_req     = '0;
        o_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_req.operation;
                    n_ino    = INO_W'(i_req.inode_number);
                    n_isdir  = i_req.is_directory;
                    n_idx    = i_req.block_index;
                    n_cnt    = '0;
                    n_blk    = '0;
                    n_newi   = '0;
                    n_status = ST_OK;
                    case (i_req.operation)
                        OP_CREATE: ib_req.op = BM_ALLOC;
                        OP_EXTEND, OP_GET, OP_CLEAR, OP_DELETE: begin
                            if (in_range) begin
                                ib_req.op  = BM_TEST;
                                ib_req.idx = BM_IDX_W'(i_req.inode_number);
                            end else begin
                                n_status = ST_INODE_FREE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CR_WAIT: begin
                if (ib_rsp.done) begin
                    if (!ib_rsp.found) begin
                        n_status = ST_NO_INODE;
                    end else begin
                        n_ino  = ib_ino;
                        cnt_we = 1'b1;
                        cnt_wa = ib_ino;
                        cnt_wd = '0;
                        if (!r_isdir) begin
                            n_newi = ib_ino;
                        end
                    end
                end
            end
            S_LIVE_WAIT: begin
                if (ib_rsp.done && !ib_rsp.found) begin
                    n_status = ST_INODE_FREE;
                end
            end
            S_CNT: begin
                n_cnt      = r_cnt_rd;
                n_i        = '0;
                n_ext_done = 1'b0;
                n_src      = idx_direct ? SRC_DIR : SRC_IND;
                if (r_op == OP_GET && get_range) begin
                    n_status = ST_RANGE;
                end
            end
            S_GROW: bb_req.op = BM_ALLOC;
            S_GR_WAIT: begin
                if (bb_rsp.done) begin
                    n_nb = bb_blk;
                    if (!bb_rsp.found) begin
                        n_status = ST_NO_BLOCK;
                    end else if (is_direct) begin
                        dir_we = 1'b1;
                        cnt_we = 1'b1;
                        if (r_op == OP_CREATE) begin
                            n_newi = r_ino;
                        end else begin
                            n_blk = bb_blk;
                        end
                    end else if (has_room) begin
                        if (!first_ind) begin
                            ind_we = 1'b1;
                            cnt_we = 1'b1;
                            n_blk  = bb_blk;
                        end
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_EXT_REQ: bb_req.op = BM_ALLOC;
            S_EXT_WAIT: begin
                if (bb_rsp.done) begin
                    if (bb_rsp.found) begin
                        ext_we = 1'b1;
                        ind_we = 1'b1;
                        map_wd = r_nb;
                        cnt_we = 1'b1;
                        n_blk  = r_nb;
                    end else begin
                        n_status = ST_NO_BLOCK;
                    end
                end
            end
            S_MAP: n_blk = (r_src == SRC_DIR) ? r_dir_rd : r_ind_rd;
            S_RL_NEXT: begin
                if (rl_more) begin
                    n_src = (32'(r_i) < 32'(DIRECT_REFS)) ? SRC_DIR : SRC_IND;
                end else begin
                    n_src = SRC_EXT;
                end
            end
            S_RL_DATA: begin
                bb_req.op  = BM_FREE;
                bb_req.idx = BM_IDX_W'(free_blk);
            end
            S_RL_WAIT: begin
                if (bb_rsp.done) begin
                    if (r_src == SRC_EXT) begin
                        n_ext_done = 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_RL_END: begin
                cnt_we = 1'b1;
                cnt_wd = '0;
            end
            S_FRB_REQ: begin
                bb_req.op  = BM_FREE;
                bb_req.idx = BM_IDX_W'(r_nb);
            end
            S_FRI_REQ: begin
                ib_req.op  = BM_FREE;
                ib_req.idx = BM_IDX_W'(r_ino);
            end
            S_RESP: o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_rsp.status    = r_status;
    assign o_rsp.new_inode = 6'(r_newi);
    assign o_rsp.blk_num   = 10'(r_blk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op       <= n_op;
        r_ino      <= n_ino;
        r_isdir    <= n_isdir;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_i        <= n_i;
        r_ext_done <= n_ext_done;
        r_src      <= n_src;
        r_nb       <= n_nb;
        r_blk      <= n_blk;
        r_status   <= n_status;
        r_newi     <= n_newi;
    end

endmodule

`default_nettype wire
